// ===== src/rcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcmr_pkg
// Shared types and constants for the rod cutting revenue block.
// ----------------------------------------------------------------------------
package rcmr_pkg;

  // Default table capacity and price width
  localparam int MaxLenDef    = 64;
  localparam int PriceBitsDef = 16;

  // Fixed field widths at the ports
  localparam int PriceInW = 16;
  localparam int RevW     = 22;
  localparam int LenOutW  = 7;
  localparam int OutDataW = 32;

  // Largest revenue the result field can carry
  localparam logic [RevW-1:0] RevMax = {RevW{1'b1}};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SWEEP,
    ST_PEND
  } rcmr_state_e;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic launch;    // inject the max token into the first cell
    logic price_we;  // store the incoming price at the write index
    logic rev_shift; // shift the revenue line by one cell
  } rcmr_ctl_t;

endpackage

// ===== src/rcmr_cell.sv =====
// ----------------------------------------------------------------------------
// rcmr_cell
// One cell of the chain: holds the price of one piece length and one entry
// of the revenue line, and folds its candidate into the passing running max.
// ----------------------------------------------------------------------------
module rcmr_cell
  import rcmr_pkg::*;
#(
  parameter int CELL_IDX   = 0,
  parameter int LEN_W      = 7,
  parameter int PRICE_BITS = PriceBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcmr_ctl_t             ctl_i,
  input  logic [LEN_W-1:0]      wr_idx_i,   // cell that takes the price
  input  logic [LEN_W-1:0]      len_i,      // length under evaluation
  input  logic [PRICE_BITS-1:0] price_i,
  input  logic [RevW-1:0]       rev_prev_i, // revenue from the left neighbor
  input  logic                  tok_i,
  input  logic [RevW-1:0]       max_i,
  output logic                  tok_o,
  output logic [RevW-1:0]       max_o,
  output logic [RevW-1:0]       rev_o
);

  localparam int SumW = ((PRICE_BITS > RevW) ? PRICE_BITS : RevW) + 1;
  localparam logic [LEN_W-1:0] MyIdx = LEN_W'(CELL_IDX);
  localparam logic [LEN_W-1:0] MyLen = LEN_W'(CELL_IDX + 1);

  logic [PRICE_BITS-1:0] price_q;
  logic [RevW-1:0]       rev_q;
  logic                  tok_q;
  logic [RevW-1:0]       max_q;
  logic [RevW-1:0]       max_d;
  logic [SumW-1:0]       sum;
  logic [RevW-1:0]       cand;
  logic                  incl;
  logic                  use_rev;

  // Pair this price with the revenue of the remaining length; the cell at
  // the far end of the current length uses the empty rod (revenue zero)
  assign incl    = (MyIdx < len_i);
  assign use_rev = (MyLen < len_i);
  assign sum     = SumW'(price_q) + (use_rev ? SumW'(rev_q) : SumW'(0));
  assign cand    = (sum > SumW'(RevMax)) ? RevMax : sum[RevW-1:0];
  assign max_d   = (incl && (cand > max_i)) ? cand : max_i;

  // Store price and shift revenue line
  always_ff @(posedge clk_i) begin
    if (ctl_i.price_we && (wr_idx_i == MyIdx)) begin
      price_q <= price_i;
    end
    if (ctl_i.rev_shift) begin
      rev_q <= rev_prev_i;
    end
    if (tok_i) begin
      max_q <= max_d;
    end
  end

  // Advance the max token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign tok_o = tok_q;
  assign max_o = max_q;
  assign rev_o = rev_q;

endmodule

// ===== src/rcmr_chain.sv =====
// ----------------------------------------------------------------------------
// rcmr_chain
// Row of MAX_LEN cells; the running max travels left to right one cell per
// cycle while the revenue line shifts right once per finished length.
// ----------------------------------------------------------------------------
module rcmr_chain
  import rcmr_pkg::*;
#(
  parameter int MAX_LEN    = MaxLenDef,
  parameter int PRICE_BITS = PriceBitsDef,
  parameter int LEN_W      = $clog2(MAX_LEN + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcmr_ctl_t             ctl_i,
  input  logic [LEN_W-1:0]      wr_idx_i,
  input  logic [LEN_W-1:0]      len_i,
  input  logic [PRICE_BITS-1:0] price_i,
  input  logic [RevW-1:0]       rev_new_i, // newest revenue, enters cell 0
  output logic                  done_o,
  output logic [RevW-1:0]       best_o
);

  logic [MAX_LEN:0]           tok;
  logic [MAX_LEN:0][RevW-1:0] mx;
  logic [MAX_LEN:0][RevW-1:0] rev;

  assign tok[0] = ctl_i.launch;
  assign mx[0]  = '0;
  assign rev[0] = rev_new_i;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    rcmr_cell #(
      .CELL_IDX  (k),
      .LEN_W     (LEN_W),
      .PRICE_BITS(PRICE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .wr_idx_i  (wr_idx_i),
      .len_i     (len_i),
      .price_i   (price_i),
      .rev_prev_i(rev[k]),
      .tok_i     (tok[k]),
      .max_i     (mx[k]),
      .tok_o     (tok[k+1]),
      .max_o     (mx[k+1]),
      .rev_o     (rev[k+1])
    );
  end

  assign done_o = tok[MAX_LEN];
  assign best_o = mx[MAX_LEN];

endmodule

// ===== src/rod_cutting_max_revenue_top.sv =====
// Flow: a stored length passes the launch state, the max token's walk along
//   the chain of MAX_LEN cells, the pending slot and the output register;
//   a beat that finds the table full goes straight to the pending slot.
//   A new beat is taken only once the previous result has left the pending slot.
// Reset: asynchronous, active low; clears the length count and all handshake
//   state. Price and revenue cells hold no value until written.
// ----------------------------------------------------------------------------
// rod_cutting_max_revenue_top
// Bottom-up rod cutting: stores one price per beat and reports the best
// revenue for the new length via a chain of cells; full-table beats overflow.
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue_top
  import rcmr_pkg::*;
#(
  parameter int MAX_LEN    = MaxLenDef,
  parameter int PRICE_BITS = PriceBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PriceInW-1:0] s_axis_tdata,  // [15:0] price
  input  logic                s_axis_tuser,  // [0] restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // [6:0] rod_length,
                                             // [28:7] best_revenue,
                                             // [29] overflow, [31:30] zero
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W-1:0] FullLen = LEN_W'(MAX_LEN);

  rcmr_state_e           state_q, state_d;
  rcmr_ctl_t             ctl;
  logic [LEN_W-1:0]      count_q;
  logic [LEN_W-1:0]      wr_idx;
  logic [PRICE_BITS-1:0] price_w;
  logic                  accept;
  logic                  table_full;
  logic                  done;
  logic [RevW-1:0]       best;
  logic                  out_free;

  logic                  pend_ovf_q;
  logic [LenOutW-1:0]    pend_len_q;
  logic [RevW-1:0]       pend_rev_q;

  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign table_full = !s_axis_tuser && (count_q == FullLen);
  assign wr_idx     = s_axis_tuser ? '0 : count_q;
  assign price_w    = PRICE_BITS'(s_axis_tdata);
  assign out_free   = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = table_full ? ST_PEND : ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (done) begin
          state_d = ST_PEND;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ctl           = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctl.price_we  = s_axis_tvalid && !table_full;
      end
      ST_LAUNCH: ctl.launch = 1'b1;
      ST_SWEEP:  ctl.rev_shift = done;
      ST_PEND:   ctl = '0;
      default:   ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Track the number of stored lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept && !table_full) begin
      count_q <= wr_idx + LEN_W'(1);
    end
  end

  rcmr_chain #(
    .MAX_LEN   (MAX_LEN),
    .PRICE_BITS(PRICE_BITS),
    .LEN_W     (LEN_W)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .wr_idx_i (wr_idx),
    .len_i    (count_q),
    .price_i  (price_w),
    .rev_new_i(best),
    .done_o   (done),
    .best_o   (best)
  );

  // Hold the finished result until the output register frees up
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && accept && table_full) begin
      pend_ovf_q <= 1'b1;
      pend_len_q <= '0;
      pend_rev_q <= '0;
    end else if ((state_q == ST_SWEEP) && done) begin
      pend_ovf_q <= 1'b0;
      pend_len_q <= LenOutW'(count_q);
      pend_rev_q <= best;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_PEND) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PEND) && out_free) begin
      out_data_q <= {2'b00, pend_ovf_q, pend_rev_q, pend_len_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  // The token leaves the chain only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == ST_SWEEP))
    else $error("max token left the chain outside the sweep");

  // The length count never passes the table capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullLen)
    else $error("length count beyond capacity");

  // A beat on a full table goes straight to the pending slot as overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && table_full) |=> ((state_q == ST_PEND) && pend_ovf_q))
    else $error("full-table beat not reported as overflow");

  // An overflow result carries neither length nor revenue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[LenOutW+RevW]) |->
      (m_axis_tdata[LenOutW+RevW-1:0] == '0))
    else $error("overflow result with nonzero payload");

  // A stored length reports the count that the beat set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SWEEP) && done) |=> (pend_len_q == LenOutW'(count_q)))
    else $error("reported length differs from count");
`endif

endmodule
